### hw/rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Shared constants, payload structs and sequencer states of the top-K heap.
// ----------------------------------------------------------------------------
package stk_pkg;

	localparam int MaxKeep = 2048;
	localparam int AddrW   = $clog2(MaxKeep);
	localparam int CountW  = $clog2(MaxKeep + 1);
	localparam int DataW   = 32;
	localparam int KeepW   = 12;
	localparam int PAddrW  = 3;
	localparam int PDataW  = 32;

	localparam logic [KeepW-1:0] KeepReset = KeepW'(2048);
	localparam logic             RegKeepCount = 1'b0;

	typedef struct packed {
		logic signed [DataW-1:0] value;
		logic                    clear_first;
	} item_t;

	typedef struct packed {
		logic signed [DataW-1:0] kth_largest;
		logic                    set_full;
	} result_t;

	typedef struct packed {
		logic signed [DataW-1:0] value;
		logic                    clear_first;
		logic [CountW-1:0]       k;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_FINISH
	} state_t;

endpackage

### hw/rtl/stk_cfg.sv
// ----------------------------------------------------------------------------
// stk_cfg
// APB register port holding keep_count and deriving the clamped heap size K.
// ----------------------------------------------------------------------------
module stk_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [stk_pkg::PAddrW-1:0]     paddr,
	input  logic [stk_pkg::PDataW-1:0]     pwdata,
	output logic [stk_pkg::PDataW-1:0]     prdata,
	output logic                           pready,
	output logic [stk_pkg::CountW-1:0]     k_eff
);

	logic [stk_pkg::KeepW-1:0] keep_q;
	logic                      hit;

	assign hit    = (paddr[2] == stk_pkg::RegKeepCount);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= stk_pkg::KeepReset;
		end else if (psel && penable && pwrite && hit) begin
			keep_q <= pwdata[stk_pkg::KeepW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = stk_pkg::PDataW'(keep_q);
		end
	end

	always_comb begin
		if (keep_q == '0) begin
			k_eff = stk_pkg::CountW'(1);
		end else if (int'(keep_q) > stk_pkg::MaxKeep) begin
			k_eff = stk_pkg::CountW'(stk_pkg::MaxKeep);
		end else begin
			k_eff = stk_pkg::CountW'(keep_q);
		end
	end

endmodule

### hw/rtl/stk_sift_engine.sv
// ----------------------------------------------------------------------------
// stk_sift_engine
// Heap memory, root cache and the sequencer that sifts one value per item.
// ----------------------------------------------------------------------------
module stk_sift_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  stk_pkg::cmd_t    cmd,
	input  logic             out_free,
	output logic             idle,
	output logic             done,
	output stk_pkg::result_t rsp
);

	localparam int AddrW  = stk_pkg::AddrW;
	localparam int CountW = stk_pkg::CountW;
	localparam int DataW  = stk_pkg::DataW;

	stk_pkg::state_t state_q, state_d;

	logic signed [DataW-1:0] mem [stk_pkg::MaxKeep];
	logic signed [DataW-1:0] rd0_q, rd1_q;
	logic signed [DataW-1:0] v_q, root_q;
	logic [CountW-1:0]       held_q, n_q, k_q;
	logic [AddrW-1:0]        pos_q;

	logic [CountW-1:0]       held_eff;
	logic                    do_ins, do_rep;
	logic                    at_top;
	logic [AddrW-1:0]        parent;
	logic [CountW-1:0]       a_idx, b_idx;
	logic                    leaf, pick_b, up_move, dn_move;
	logic signed [DataW-1:0] cval;
	logic [AddrW-1:0]        pidx;

	logic                    mem_we, rd_en, root_we, pos_we;
	logic [AddrW-1:0]        mem_waddr, rd_addr0, rd_addr1, pos_d;
	logic signed [DataW-1:0] mem_wdata, root_d;

	// shared compare and index logic
	always_comb begin
		held_eff = cmd.clear_first ? '0 : held_q;
		do_ins   = held_eff < cmd.k;
		do_rep   = cmd.value > root_q;
		at_top   = (pos_q == '0);
		parent   = AddrW'((pos_q - 1'b1) >> 1);
		a_idx    = {pos_q, 1'b1};
		b_idx    = CountW'(a_idx + 1'b1);
		leaf     = (a_idx >= n_q);
		pick_b   = (b_idx < n_q) && !(rd0_q < rd1_q);
		cval     = pick_b ? rd1_q : rd0_q;
		pidx     = pick_b ? b_idx[AddrW-1:0] : a_idx[AddrW-1:0];
		up_move  = rd0_q > v_q;
		dn_move  = v_q > cval;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			stk_pkg::S_IDLE: begin
				if (start) begin
					if (do_ins) begin
						state_d = stk_pkg::S_UP_RD;
					end else if (do_rep) begin
						state_d = stk_pkg::S_DN_RD;
					end else begin
						state_d = stk_pkg::S_FINISH;
					end
				end
			end
			stk_pkg::S_UP_RD: begin
				state_d = at_top ? stk_pkg::S_FINISH : stk_pkg::S_UP_CMP;
			end
			stk_pkg::S_UP_CMP: begin
				state_d = up_move ? stk_pkg::S_UP_RD : stk_pkg::S_FINISH;
			end
			stk_pkg::S_DN_RD: begin
				state_d = leaf ? stk_pkg::S_FINISH : stk_pkg::S_DN_CMP;
			end
			stk_pkg::S_DN_CMP: begin
				state_d = dn_move ? stk_pkg::S_DN_RD : stk_pkg::S_FINISH;
			end
			stk_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = stk_pkg::S_IDLE;
				end
			end
			default: state_d = stk_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		idle      = 1'b0;
		done      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = v_q;
		rd_en     = 1'b0;
		rd_addr0  = parent;
		rd_addr1  = b_idx[AddrW-1:0];
		root_we   = 1'b0;
		root_d    = v_q;
		pos_we    = 1'b0;
		pos_d     = pos_q;
		case (state_q)
			stk_pkg::S_IDLE: begin
				idle = 1'b1;
			end
			stk_pkg::S_UP_RD: begin
				if (at_top) begin
					mem_we  = 1'b1;
					root_we = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			stk_pkg::S_UP_CMP: begin
				mem_we = 1'b1;
				if (up_move) begin
					mem_wdata = rd0_q;
					pos_we    = 1'b1;
					pos_d     = parent;
				end
			end
			stk_pkg::S_DN_RD: begin
				rd_addr0 = a_idx[AddrW-1:0];
				if (leaf) begin
					mem_we  = 1'b1;
					root_we = at_top;
				end else begin
					rd_en = 1'b1;
				end
			end
			stk_pkg::S_DN_CMP: begin
				mem_we  = 1'b1;
				root_we = at_top;
				if (dn_move) begin
					mem_wdata = cval;
					root_d    = cval;
					pos_we    = 1'b1;
					pos_d     = pidx;
				end
			end
			stk_pkg::S_FINISH: begin
				done = out_free;
			end
			default: ;
		endcase
	end

	assign rsp.kth_largest = root_q;
	assign rsp.set_full    = (held_q >= k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stk_pkg::S_IDLE;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start && idle) begin
				held_q <= do_ins ? CountW'(held_eff + 1'b1) : held_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && idle) begin
			v_q   <= cmd.value;
			k_q   <= cmd.k;
			n_q   <= held_eff;
			pos_q <= do_ins ? held_eff[AddrW-1:0] : '0;
		end else if (pos_we) begin
			pos_q <= pos_d;
		end
		if (root_we) begin
			root_q <= root_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd0_q <= mem[rd_addr0];
			rd1_q <= mem[rd_addr1];
		end
	end

endmodule

### hw/rtl/streaming_top_k_min_heap_core.sv
// ----------------------------------------------------------------------------
// streaming_top_k_min_heap_core
// Keeps the K largest values of a signed stream in a min-heap and reports the
// root (the K-th largest) and a full flag for every transfer in. One item is
// worked at a time by a sequencer over a single heap memory with one write
// and two registered read ports, with a read and a compare state per heap
// level. A dropped value goes straight to the finish state; an insert climbs
// from the new slot toward the root and a root replacement sinks toward a
// leaf, each ending there or where a compare stops it, and either moves at
// most eleven levels with K = 2048. The finish state waits for the output
// register to be free, and the next item is taken while a result still
// waits at that register. The heap holds no reset state, so there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module streaming_top_k_min_heap_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  stk_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output stk_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [stk_pkg::PAddrW-1:0] paddr,
	input  logic [stk_pkg::PDataW-1:0] pwdata,
	output logic [stk_pkg::PDataW-1:0] prdata,
	output logic                       pready
);

	logic [stk_pkg::CountW-1:0] k_eff;
	stk_pkg::cmd_t              cmd;
	stk_pkg::result_t           rsp, result_q;
	logic                       eng_idle, eng_done, out_free, result_valid_q;

	stk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.k_eff   (k_eff)
	);

	assign cmd.value       = item.value;
	assign cmd.clear_first = item.clear_first;
	assign cmd.k           = k_eff;

	assign item_ready = eng_idle;
	assign out_free   = !result_valid_q || result_ready;

	stk_sift_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (item_valid && item_ready),
		.cmd      (cmd),
		.out_free (out_free),
		.idle     (eng_idle),
		.done     (eng_done),
		.rsp      (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (eng_done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			result_q <= rsp;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### sim/streaming_top_k_min_heap_core_tb.sv
// ----------------------------------------------------------------------------
// streaming_top_k_min_heap_core_tb
// Streams signed samples into the top-K heap core and checks each root and
// full flag against a software min-heap. The keep count is retuned between
// phases, and the extremes are covered: zero, one, above the heap size, and
// lowered below the number held. Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module streaming_top_k_min_heap_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ItemTarget = 1050;
	localparam int IdleLimit  = 5000;
	localparam int Drain      = 30;
	localparam logic [stk_pkg::PAddrW-1:0] KeepAddr =
		stk_pkg::PAddrW'(4 * stk_pkg::RegKeepCount);
	localparam logic signed [stk_pkg::DataW-1:0] MinVal = 32'sh8000_0000;
	localparam logic signed [stk_pkg::DataW-1:0] MaxVal = 32'sh7fff_ffff;

	class kth_tracker;
		logic signed [stk_pkg::DataW-1:0] slots [stk_pkg::MaxKeep];
		int unsigned                      held;
		logic [stk_pkg::KeepW-1:0]        keep;
		stk_pkg::result_t                 due_roots [$];
		int                               errors;

		function new();
			held   = 0;
			keep   = stk_pkg::KeepReset;
			errors = 0;
		endfunction

		function void set_keep(logic [stk_pkg::KeepW-1:0] k);
			keep = k;
		endfunction

		function int pending();
			return due_roots.size();
		endfunction

		function void take_value(stk_pkg::item_t it);
			int unsigned                      k, pos, up, a, b, pick;
			logic signed [stk_pkg::DataW-1:0] t;
			stk_pkg::result_t                 r;
			k = (keep == 0) ? 1 :
				((keep > stk_pkg::MaxKeep) ? stk_pkg::MaxKeep : keep);
			if (it.clear_first)
				held = 0;
			if (held < k) begin
				slots[held] = it.value;
				pos = held;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (slots[up] > slots[pos]) begin
						t = slots[up];
						slots[up] = slots[pos];
						slots[pos] = t;
						pos = up;
					end else begin
						break;
					end
				end
				held++;
			end else if (it.value > slots[0]) begin
				slots[0] = it.value;
				pos = 0;
				forever begin
					a = 2 * pos + 1;
					b = a + 1;
					if (a >= held)
						break;
					pick = a;
					if (b < held && !(slots[a] < slots[b]))
						pick = b;
					if (slots[pos] > slots[pick]) begin
						t = slots[pos];
						slots[pos] = slots[pick];
						slots[pick] = t;
						pos = pick;
					end else begin
						break;
					end
				end
			end
			r.kth_largest = (held > 0) ? slots[0] : '0;
			r.set_full    = (held >= k);
			due_roots.push_back(r);
		endfunction

		function void check_root(stk_pkg::result_t got);
			stk_pkg::result_t want;
			if (due_roots.size() == 0) begin
				$error("unexpected result: kth_largest %0d set_full %0d",
					got.kth_largest, got.set_full);
				errors++;
				return;
			end
			want = due_roots.pop_front();
			if (got.kth_largest !== want.kth_largest) begin
				$error("kth_largest: expected %0d, got %0d", want.kth_largest, got.kth_largest);
				errors++;
			end
			if (got.set_full !== want.set_full) begin
				$error("set_full: expected %0d, got %0d", want.set_full, got.set_full);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       item_valid;
	logic                       item_ready;
	stk_pkg::item_t             item;
	logic                       result_valid;
	logic                       result_ready;
	stk_pkg::result_t           result;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [stk_pkg::PAddrW-1:0] paddr;
	logic [stk_pkg::PDataW-1:0] pwdata;
	logic [stk_pkg::PDataW-1:0] prdata;
	logic                       pready;

	kth_tracker tracker = new();
	int         sent = 0;

	streaming_top_k_min_heap_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 60);
	endfunction

	function automatic logic signed [stk_pkg::DataW-1:0] pick_value();
		logic signed [stk_pkg::DataW-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = stk_pkg::DataW'($urandom_range(0, 16)) - 32'sd8;
			4: begin
				case ($urandom_range(0, 3))
					0: v = MinVal;
					1: v = MaxVal;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [stk_pkg::KeepW-1:0] pick_keep();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return stk_pkg::KeepW'($urandom_range(1, 16));
		if (r < 75)
			return stk_pkg::KeepW'($urandom_range(17, 64));
		if (r < 85)
			return '0;
		if (r < 90)
			return stk_pkg::KeepW'($urandom_range(2048, 4095));
		return stk_pkg::KeepW'($urandom_range(65, 300));
	endfunction

	// transfer monitor: results first, so a same-edge input never satisfies itself
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				tracker.check_root(result);
			if (item_valid && item_ready)
				tracker.take_value(item);
		end
	end

	initial begin
		int   span;
		logic lvl;
		result_ready <= 1'b0;
		span = 0;
		lvl  = 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				lvl  = !lvl;
				span = lvl ? $urandom_range(1, 40) : pick_gap() + 1;
			end
			span--;
			result_ready <= lvl;
		end
	end

	task automatic send(input logic signed [stk_pkg::DataW-1:0] v, input logic clr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{value: v, clear_first: clr};
		do @(posedge clk); while (!item_ready);
		sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic retune(input logic [stk_pkg::KeepW-1:0] k);
		logic [31:0] junk;
		junk = $urandom;
		wait_drained();
		repeat (4) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= KeepAddr;
		pwdata  <= {junk[31:stk_pkg::KeepW], k};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_keep(k);
	endtask

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IdleLimit) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
			    (psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int                        len, pause_at;
		logic                      clr, start_clear;
		logic [stk_pkg::KeepW-1:0] k;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset keep count: inserts only, never full
		send(32'sd0, 1'b0);
		send(-32'sd1, 1'b0);
		send(MaxVal, 1'b0);
		send(MinVal, 1'b0);
		send(32'sd5, 1'b0);
		send(32'sd5, 1'b0);

		// small set: drops, ties at the root, replacement and sift down
		retune(stk_pkg::KeepW'(3));
		send(32'sd10, 1'b1);
		send(32'sd20, 1'b0);
		send(32'sd30, 1'b0);
		send(32'sd10, 1'b0);
		send(32'sd5, 1'b0);
		send(32'sd25, 1'b0);
		send(32'sd30, 1'b0);
		send(MinVal, 1'b0);
		send(MaxVal, 1'b0);

		// lowered below the held count without a clear
		retune(stk_pkg::KeepW'(1));
		send(32'sd40, 1'b0);
		send(32'sd1, 1'b0);

		// zero acts as one
		retune('0);
		send(-32'sd7, 1'b1);
		send(32'sd100, 1'b0);

		// above the heap size acts as the heap size
		retune(stk_pkg::KeepW'(4095));
		send(MaxVal, 1'b1);
		send(MinVal, 1'b0);
		send(32'sd3, 1'b0);

		retune(stk_pkg::KeepW'(2048));
		send(32'sd9, 1'b1);
		send(-32'sd9, 1'b0);

		pause_at = 10;
		while (sent < ItemTarget) begin
			k = pick_keep();
			retune(k);
			len = (k > 64) ? $urandom_range(20, 100) : $urandom_range(15, 70);
			start_clear = ($urandom_range(0, 9) < 7);
			for (int i = 0; i < len; i++) begin
				if (i == pause_at)
					wait_drained();
				clr = (i == 0 && start_clear) || ($urandom_range(0, 39) == 0);
				send(pick_value(), clr);
			end
			pause_at = $urandom_range(0, 400);
		end

		item_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (Drain) @(posedge clk);
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
